### hw/rtl/fxalu_pkg.sv
package fxalu_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int WORD_BITS_DEF     = 32;
  localparam int FIFO_DEPTH        = 2;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_MIN   = 4'd4,
    OP_MAX   = 4'd5,
    OP_INC   = 4'd6,
    OP_DEC   = 4'd7,
    OP_FROMI = 4'd8,
    OP_TOI   = 4'd9,
    OP_NONE  = 4'd15
  } op_t;

  typedef struct packed {
    op_t  op;
    logic lt;
    logic eq;
    logic gt;
  } cls_t;

endpackage

### hw/rtl/fxalu_front.sv
module fxalu_front #(
  parameter int WORD_BITS = fxalu_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_command,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  input  logic                        q_full,
  output logic                        q_push,
  output fxalu_pkg::cls_t             q_cls,
  output logic [WORD_BITS-1:0]        q_a,
  output logic [WORD_BITS-1:0]        q_b
);

  logic                 v_r;
  fxalu_pkg::cls_t      cls_r, cls_nxt;
  logic [WORD_BITS-1:0] a_r, b_r;
  logic                 take;

  assign busy   = v_r && q_full;
  assign take   = start && !busy;
  assign q_push = v_r && !q_full;
  assign q_cls  = cls_r;
  assign q_a    = a_r;
  assign q_b    = b_r;

  always_comb begin
    if (in_command inside {[fxalu_pkg::OP_ADD:fxalu_pkg::OP_TOI]}) begin
      cls_nxt.op = fxalu_pkg::op_t'(in_command);
    end else begin
      cls_nxt.op = fxalu_pkg::OP_NONE;
    end
    cls_nxt.lt = in_operand_a < in_operand_b;
    cls_nxt.eq = in_operand_a == in_operand_b;
    cls_nxt.gt = in_operand_a > in_operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (take) begin
      v_r <= 1'b1;
    end else if (q_push) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= cls_nxt;
      a_r   <= in_operand_a;
      b_r   <= in_operand_b;
    end
  end

endmodule

### hw/rtl/fxalu_fifo.sv
module fxalu_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  output logic          pop,
  output logic [DW-1:0] rdata
);

  localparam int AW = $clog2(fxalu_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(fxalu_pkg::FIFO_DEPTH + 1);

  logic [DW-1:0] mem [fxalu_pkg::FIFO_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = cnt_r == CW'(fxalu_pkg::FIFO_DEPTH);
  // back end never stalls: drain whenever something is held
  assign pop   = cnt_r != '0;
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule

### hw/rtl/fxalu_back.sv
module fxalu_back #(
  parameter int FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEF,
  parameter int WORD_BITS     = fxalu_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_v,
  input  fxalu_pkg::cls_t             req_cls,
  input  logic [WORD_BITS-1:0]        req_a,
  input  logic [WORD_BITS-1:0]        req_b,
  output logic                        out_strobe,
  output logic signed [WORD_BITS-1:0] out_result_value,
  output logic                        out_a_less,
  output logic                        out_a_equal,
  output logic                        out_a_greater,
  output logic                        out_overflowed,
  output logic                        out_divided_by_zero
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int NW = W + F + 2;
  localparam int PW = 2 * W;

  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

  // ---- stage 1: multiply and divide operand prep
  logic                  v1_r;
  fxalu_pkg::cls_t       c1_r;
  logic [W-1:0]          a1_r, b1_r;
  logic signed [PW-1:0]  p1_r;
  logic [NW-1:0]         n1_r;
  logic [W:0]            d1_r;
  logic                  ng1_r;

  logic signed [W:0]     as, bs;
  logic signed [NW:0]    num;
  logic [NW:0]           nabs;

  always_comb begin
    as = $signed({req_a[W-1], req_a});
    bs = $signed({req_b[W-1], req_b});
    if (req_b[W-1]) begin
      as = -as;
      bs = -bs;
    end
    num  = $signed({as[W], as, {(F+1){1'b0}}}) + $signed({{(F+2){bs[W]}}, bs});
    nabs = num[NW] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= req_v;
  end

  always_ff @(posedge clk) begin
    c1_r  <= req_cls;
    a1_r  <= req_a;
    b1_r  <= req_b;
    p1_r  <= PW'($signed(req_a)) * PW'($signed(req_b));
    n1_r  <= nabs[NW-1:0];
    d1_r  <= {bs[W-1:0], 1'b0};
    ng1_r <= num[NW];
  end

  // ---- stage 2: simple results, rounding, divide range check
  logic [W-1:0]          r2_nxt;
  logic                  o2_nxt;

  logic signed [W:0]     sum;
  logic signed [PW-1:0]  pr;
  logic signed [PW-1:0]  psh;
  logic [NW-W-1:0]       nhi;

  // divide stage registers; entry 0 is loaded by stage 2
  logic            dv_r  [W+1];
  fxalu_pkg::cls_t dc_r  [W+1];
  logic [W-1:0]    dr_r  [W+1];
  logic            do_r  [W+1];
  logic            dbig_r[W+1];
  logic            dng_r [W+1];
  logic            dbz_r [W+1];
  logic            das_r [W+1];
  logic [W:0]      drm_r [W+1];
  logic [W:0]      dd_r  [W+1];
  logic [W-1:0]    dnl_r [W+1];
  logic [W-1:0]    dq_r  [W+1];

  always_comb begin
    sum    = '0;
    pr     = p1_r + $signed(PW'(1) << (F - 1));
    psh    = pr >>> F;
    r2_nxt = '0;
    o2_nxt = 1'b0;
    case (c1_r.op)
      fxalu_pkg::OP_ADD, fxalu_pkg::OP_SUB, fxalu_pkg::OP_INC, fxalu_pkg::OP_DEC: begin
        case (c1_r.op)
          fxalu_pkg::OP_ADD: sum = $signed({a1_r[W-1], a1_r}) + $signed({b1_r[W-1], b1_r});
          fxalu_pkg::OP_SUB: sum = $signed({a1_r[W-1], a1_r}) - $signed({b1_r[W-1], b1_r});
          fxalu_pkg::OP_INC: sum = $signed({a1_r[W-1], a1_r}) + $signed((W+1)'(1));
          default:           sum = $signed({a1_r[W-1], a1_r}) - $signed((W+1)'(1));
        endcase
        o2_nxt = sum[W] != sum[W-1];
        r2_nxt = o2_nxt ? (sum[W] ? MINN : MAXP) : sum[W-1:0];
      end
      fxalu_pkg::OP_MUL: begin
        o2_nxt = !((&psh[PW-1:W-1]) || !(|psh[PW-1:W-1]));
        r2_nxt = o2_nxt ? (psh[PW-1] ? MINN : MAXP) : psh[W-1:0];
      end
      fxalu_pkg::OP_MIN: r2_nxt = c1_r.lt ? a1_r : b1_r;
      fxalu_pkg::OP_MAX: r2_nxt = c1_r.gt ? a1_r : b1_r;
      fxalu_pkg::OP_FROMI: begin
        o2_nxt = !((&a1_r[W-1:W-1-F]) || !(|a1_r[W-1:W-1-F]));
        r2_nxt = o2_nxt ? (a1_r[W-1] ? MINN : MAXP) : (a1_r << F);
      end
      fxalu_pkg::OP_TOI: r2_nxt = W'($signed(a1_r) >>> F);
      default: ;
    endcase
  end

  assign nhi = n1_r[NW-1:W];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= v1_r;
  end

  always_ff @(posedge clk) begin
    dc_r[0]   <= c1_r;
    dr_r[0]   <= r2_nxt;
    do_r[0]   <= o2_nxt;
    dbig_r[0] <= {{(W+1){1'b0}}, nhi} >= {{(NW-W){1'b0}}, d1_r};
    drm_r[0]  <= (W+1)'(nhi);
    dd_r[0]   <= d1_r;
    dnl_r[0]  <= n1_r[W-1:0];
    dng_r[0]  <= ng1_r;
    dbz_r[0]  <= b1_r == '0;
    das_r[0]  <= a1_r[W-1];
    dq_r[0]   <= '0;
  end

  // ---- divide stages: one quotient bit each
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W+1:0] t;
    logic         ge;
    logic [W+1:0] tm;

    assign t  = {drm_r[k], dnl_r[k][W-1-k]};
    assign ge = t >= {1'b0, dd_r[k]};
    assign tm = ge ? t - {1'b0, dd_r[k]} : t;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
    end

    always_ff @(posedge clk) begin
      dc_r[k+1]   <= dc_r[k];
      dr_r[k+1]   <= dr_r[k];
      do_r[k+1]   <= do_r[k];
      dbig_r[k+1] <= dbig_r[k];
      dng_r[k+1]  <= dng_r[k];
      dbz_r[k+1]  <= dbz_r[k];
      das_r[k+1]  <= das_r[k];
      drm_r[k+1]  <= tm[W:0];
      dd_r[k+1]   <= dd_r[k];
      dnl_r[k+1]  <= dnl_r[k];
      dq_r[k+1]   <= {dq_r[k][W-2:0], ge};
    end
  end

  // ---- output stage
  logic         os_r;
  logic [W-1:0] ores_r, ores_nxt;
  logic         oovf_r, oovf_nxt, odbz_r, odbz_nxt;
  logic         olt_r, oeq_r, ogt_r;
  logic [W:0]   qc;

  always_comb begin
    qc       = {1'b0, dq_r[W]} + (W+1)'(drm_r[W] != '0);
    ores_nxt = dr_r[W];
    oovf_nxt = do_r[W];
    odbz_nxt = 1'b0;
    if (dc_r[W].op == fxalu_pkg::OP_DIV) begin
      if (dbz_r[W]) begin
        odbz_nxt = 1'b1;
        oovf_nxt = 1'b1;
        ores_nxt = das_r[W] ? MINN : MAXP;
      end else if (dng_r[W]) begin
        oovf_nxt = dbig_r[W] || qc > {1'b0, MINN};
        ores_nxt = oovf_nxt ? MINN : W'(-qc);
      end else begin
        oovf_nxt = dbig_r[W] || dq_r[W] > MAXP;
        ores_nxt = oovf_nxt ? MAXP : dq_r[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) os_r <= 1'b0;
    else        os_r <= dv_r[W];
  end

  always_ff @(posedge clk) begin
    ores_r <= ores_nxt;
    oovf_r <= oovf_nxt;
    odbz_r <= odbz_nxt;
    olt_r  <= dc_r[W].lt;
    oeq_r  <= dc_r[W].eq;
    ogt_r  <= dc_r[W].gt;
  end

  assign out_strobe          = os_r;
  assign out_result_value    = ores_r;
  assign out_a_less          = olt_r;
  assign out_a_equal         = oeq_r;
  assign out_a_greater       = ogt_r;
  assign out_overflowed      = oovf_r;
  assign out_divided_by_zero = odbz_r;

endmodule

### hw/rtl/fixed_point_q24_8_alu_top.sv
// Channel   Ports                                          Direction
// request   start, busy, in_command, in_operand_a/b        in (busy out)
// result    out_strobe, out_result_value, out_a_less,      out
//           out_a_equal, out_a_greater, out_overflowed,
//           out_divided_by_zero
//
// One request per cycle is taken while busy is low; results appear in the order of their
// requests. The divide pipeline computes one quotient bit per stage.
// Reset empties the front register, the queue and all pipeline valid bits.
// The receiver cannot stall, so the back end drains the queue every cycle and busy
// stays low in normal operation.
module fixed_point_q24_8_alu_top #(
  parameter int FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEF,
  parameter int WORD_BITS     = fxalu_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_command,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_strobe,
  output logic signed [WORD_BITS-1:0] out_result_value,
  output logic                        out_a_less,
  output logic                        out_a_equal,
  output logic                        out_a_greater,
  output logic                        out_overflowed,
  output logic                        out_divided_by_zero
);

  localparam int CB = $bits(fxalu_pkg::cls_t);
  localparam int DW = CB + 2 * WORD_BITS;

  logic                 q_full, q_push, q_pop;
  fxalu_pkg::cls_t      f_cls, b_cls;
  logic [WORD_BITS-1:0] f_a, f_b, b_a, b_b;
  logic [DW-1:0]        q_rd;

  fxalu_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cls        (f_cls),
    .q_a          (f_a),
    .q_b          (f_b)
  );

  fxalu_fifo #(.DW(DW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_cls, f_a, f_b}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rd)
  );

  assign b_cls = fxalu_pkg::cls_t'(q_rd[DW-1 -: CB]);
  assign b_a   = q_rd[2*WORD_BITS-1 -: WORD_BITS];
  assign b_b   = q_rd[WORD_BITS-1:0];

  fxalu_back #(.FRACTION_BITS(FRACTION_BITS), .WORD_BITS(WORD_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_v               (q_pop),
    .req_cls             (b_cls),
    .req_a               (b_a),
    .req_b               (b_b),
    .out_strobe          (out_strobe),
    .out_result_value    (out_result_value),
    .out_a_less          (out_a_less),
    .out_a_equal         (out_a_equal),
    .out_a_greater       (out_a_greater),
    .out_overflowed      (out_overflowed),
    .out_divided_by_zero (out_divided_by_zero)
  );

endmodule
